// ----- rtl/core/flw_pkg.sv -----
// shared types and constants for the four-connected line walker
// no dependencies; every other file refers to this package by scoped names
package flw_pkg;

  localparam int unsigned COORD_W = 16;
  // coordinate plus one bit so neighbors and differences never wrap
  localparam int unsigned XW      = COORD_W + 1;
  // cross product |b| * |p - a| stays below 2^(2*XW)
  localparam int unsigned CROSS_W = 2 * XW + 2;
  // squared distance offset of one unit move: +-2*(p - end) + 1
  localparam int unsigned DOFF_W  = XW + 2;
  localparam int unsigned CAP_W   = 16;

  localparam logic [CAP_W-1:0] STEP_CAP_RESET = CAP_W'(1000);

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [1:0] ST_MOVING  = 2'd0;
  localparam logic [1:0] ST_REACHED = 2'd1;
  localparam logic [1:0] ST_CAP     = 2'd2;
  localparam logic [1:0] ST_STUCK   = 2'd3;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;
  localparam logic [2:0] NO_MOVE   = 3'd4;

  typedef struct packed {
    logic               opcode;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [1:0]         move_dir;
    logic [1:0]         status;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic               is_start;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic [XW-1:0]      bx;
    logic [XW-1:0]      by;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_y;
    logic               ab_same;
  } cmd_t;

  function automatic logic [XW-1:0] sext_x(input logic [COORD_W-1:0] v);
    return {v[COORD_W-1], v};
  endfunction

endpackage

// ----- rtl/core/flw_front.sv -----
// front stage: registers an incoming item and precomputes the line setup of a start
// depends on flw_pkg
module flw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  flw_pkg::in_item_t item_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output flw_pkg::cmd_t     cmd_o
);

  logic               valid_q;
  flw_pkg::cmd_t      cmd_q;
  flw_pkg::cmd_t      cmd_d;
  logic               take;
  logic [flw_pkg::XW-1:0] sx_e;
  logic [flw_pkg::XW-1:0] sy_e;
  logic [flw_pkg::XW-1:0] ex_e;
  logic [flw_pkg::XW-1:0] ey_e;
  logic               x_lt;
  logic               y_lt;

  assign full_o      = valid_q && !cmd_ready_i;
  assign take        = push_i && !full_o;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    sx_e = flw_pkg::sext_x(item_i.start_x);
    sy_e = flw_pkg::sext_x(item_i.start_y);
    ex_e = flw_pkg::sext_x(item_i.end_x);
    ey_e = flw_pkg::sext_x(item_i.end_y);
    x_lt = $signed(sx_e) < $signed(ex_e);
    y_lt = $signed(sy_e) < $signed(ey_e);
    cmd_d.is_start = (item_i.opcode == flw_pkg::OP_START);
    cmd_d.sx       = item_i.start_x;
    cmd_d.sy       = item_i.start_y;
    cmd_d.ex       = item_i.end_x;
    cmd_d.ey       = item_i.end_y;
    cmd_d.bx       = ex_e - sx_e;
    cmd_d.by       = ey_e - sy_e;
    cmd_d.min_x    = x_lt ? item_i.start_x : item_i.end_x;
    cmd_d.max_x    = x_lt ? item_i.end_x : item_i.start_x;
    cmd_d.min_y    = y_lt ? item_i.start_y : item_i.end_y;
    cmd_d.max_y    = y_lt ? item_i.end_y : item_i.start_y;
    cmd_d.ab_same  = (item_i.start_x == item_i.end_x) && (item_i.start_y == item_i.end_y);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (cmd_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ----- rtl/core/flw_cmd_queue.sv -----
// two-entry command queue between the front and back stages
// depends on flw_pkg
module flw_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  flw_pkg::cmd_t in_cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output flw_pkg::cmd_t out_cmd_o
);

  flw_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    count_q;
  logic          wr_en;
  logic          rd_en;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_cmd_o   = mem_q[rd_ptr_q];
  assign wr_en       = in_valid_i && in_ready_o;
  assign rd_en       = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + 2'd1;
      end else if (rd_en && !wr_en) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= in_cmd_i;
    end
  end

endmodule

// ----- rtl/core/flw_back.sv -----
// back stage: walker state, one step per cycle while the result queue has room, and the two-entry result queue
// depends on flw_pkg
module flw_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [flw_pkg::CAP_W-1:0]     cfg_wdata_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  flw_pkg::cmd_t                 cmd_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output flw_pkg::out_item_t            out_item_o
);

  localparam int unsigned CW = flw_pkg::COORD_W;
  localparam int unsigned XW = flw_pkg::XW;
  localparam int unsigned RW = flw_pkg::CROSS_W;
  localparam int unsigned DW = flw_pkg::DOFF_W;

  // walker state
  logic [flw_pkg::CAP_W-1:0] cap_q;
  logic [CW-1:0]             ex_q, ey_q;
  logic [CW-1:0]             min_x_q, max_x_q, min_y_q, max_y_q;
  logic [XW-1:0]             bx_q, by_q;
  logic [CW-1:0]             cx_q, cy_q;
  logic [RW-1:0]             cross_q;
  logic [2:0]                last_q;
  logic [flw_pkg::CAP_W-1:0] steps_q;

  // result queue
  flw_pkg::out_item_t        oq_mem_q [2];
  logic                      oq_wr_q, oq_rd_q;
  logic [1:0]                oq_cnt_q;
  logic                      oq_push, oq_pop;
  flw_pkg::out_item_t        res;

  logic                      exec;
  logic [XW-1:0]             cx_e, cy_e, ux, uy;
  logic [RW-1:0]             bx_r, by_r;
  logic [DW-1:0]             ux2, uy2;
  logic [XW-1:0]             cand_x [4];
  logic [XW-1:0]             cand_y [4];
  logic [RW-1:0]             cross_s [4];
  logic [RW-1:0]             cross_a [4];
  logic [DW-1:0]             doff [4];
  logic [3:0]                legal;
  logic                      at_end, cap_hit;
  logic [1:0]                sel01, sel23, best;
  logic                      v01, v23, any_legal;
  logic [flw_pkg::CAP_W-1:0] steps_inc;
  logic [CW-1:0]             nx, ny;

  // candidate b strictly better than a: smaller cross, or equal cross and closer to end
  function automatic logic beats(input logic [RW-1:0] cr_b, input logic [DW-1:0] d_b,
                                 input logic [RW-1:0] cr_a, input logic [DW-1:0] d_a);
    return (cr_b < cr_a) || ((cr_b == cr_a) && ($signed(d_b) < $signed(d_a)));
  endfunction

  assign oq_push     = exec;
  assign oq_pop      = pop_i && !empty_o;
  assign empty_o     = (oq_cnt_q == 2'd0);
  assign out_item_o  = oq_mem_q[oq_rd_q];
  assign cmd_ready_o = (oq_cnt_q != 2'd2);
  assign exec        = cmd_valid_i && cmd_ready_o;

  always_comb begin
    cx_e = flw_pkg::sext_x(cx_q);
    cy_e = flw_pkg::sext_x(cy_q);
    ux   = cx_e - flw_pkg::sext_x(ex_q);
    uy   = cy_e - flw_pkg::sext_x(ey_q);
    ux2  = {ux[XW-1], ux, 1'b0};
    uy2  = {uy[XW-1], uy, 1'b0};
    bx_r = {{(RW-XW){bx_q[XW-1]}}, bx_q};
    by_r = {{(RW-XW){by_q[XW-1]}}, by_q};

    cand_x[flw_pkg::DIR_UP]    = cx_e;
    cand_y[flw_pkg::DIR_UP]    = cy_e - XW'(1);
    cand_x[flw_pkg::DIR_LEFT]  = cx_e - XW'(1);
    cand_y[flw_pkg::DIR_LEFT]  = cy_e;
    cand_x[flw_pkg::DIR_DOWN]  = cx_e;
    cand_y[flw_pkg::DIR_DOWN]  = cy_e + XW'(1);
    cand_x[flw_pkg::DIR_RIGHT] = cx_e + XW'(1);
    cand_y[flw_pkg::DIR_RIGHT] = cy_e;

    // cross product moves by bx per unit of y and by -by per unit of x
    cross_s[flw_pkg::DIR_UP]    = cross_q - bx_r;
    cross_s[flw_pkg::DIR_LEFT]  = cross_q + by_r;
    cross_s[flw_pkg::DIR_DOWN]  = cross_q + bx_r;
    cross_s[flw_pkg::DIR_RIGHT] = cross_q - by_r;

    // squared distance to end relative to the current point
    doff[flw_pkg::DIR_UP]    = DW'(1) - uy2;
    doff[flw_pkg::DIR_LEFT]  = DW'(1) - ux2;
    doff[flw_pkg::DIR_DOWN]  = DW'(1) + uy2;
    doff[flw_pkg::DIR_RIGHT] = DW'(1) + ux2;

    for (int i = 0; i < 4; i++) begin
      cross_a[i] = cross_s[i][RW-1] ? (RW'(0) - cross_s[i]) : cross_s[i];
      legal[i]   = !((last_q != flw_pkg::NO_MOVE) && ((last_q[1:0] ^ 2'b10) == 2'(i)))
                   && ($signed(cand_x[i]) >= $signed(flw_pkg::sext_x(min_x_q)))
                   && ($signed(cand_x[i]) <= $signed(flw_pkg::sext_x(max_x_q)))
                   && ($signed(cand_y[i]) >= $signed(flw_pkg::sext_x(min_y_q)))
                   && ($signed(cand_y[i]) <= $signed(flw_pkg::sext_x(max_y_q)));
    end

    // selection tree, earlier direction wins a full tie
    sel01 = (!legal[0] || (legal[1] && beats(cross_a[1], doff[1], cross_a[0], doff[0])))
            ? 2'd1 : 2'd0;
    sel23 = (!legal[2] || (legal[3] && beats(cross_a[3], doff[3], cross_a[2], doff[2])))
            ? 2'd3 : 2'd2;
    v01   = legal[0] || legal[1];
    v23   = legal[2] || legal[3];
    best  = (v23 && (!v01 || beats(cross_a[sel23], doff[sel23], cross_a[sel01], doff[sel01])))
            ? sel23 : sel01;
    any_legal = v01 || v23;

    at_end    = (cx_q == ex_q) && (cy_q == ey_q);
    cap_hit   = (steps_q >= cap_q);
    steps_inc = steps_q + flw_pkg::CAP_W'(1);
    nx        = cand_x[best][CW-1:0];
    ny        = cand_y[best][CW-1:0];

    res.pos_x    = cx_q;
    res.pos_y    = cy_q;
    res.move_dir = flw_pkg::DIR_UP;
    res.status   = flw_pkg::ST_MOVING;
    if (cmd_i.is_start) begin
      res.pos_x  = cmd_i.sx;
      res.pos_y  = cmd_i.sy;
      res.status = cmd_i.ab_same ? flw_pkg::ST_REACHED : flw_pkg::ST_MOVING;
    end else if (at_end) begin
      res.status = flw_pkg::ST_REACHED;
    end else if (cap_hit) begin
      res.status = flw_pkg::ST_CAP;
    end else if (!any_legal) begin
      res.status = flw_pkg::ST_STUCK;
    end else begin
      res.pos_x    = nx;
      res.pos_y    = ny;
      res.move_dir = best;
      if (steps_inc >= cap_q) begin
        res.status = flw_pkg::ST_CAP;
      end else if ((nx == ex_q) && (ny == ey_q)) begin
        res.status = flw_pkg::ST_REACHED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= flw_pkg::STEP_CAP_RESET;
      ex_q    <= '0;
      ey_q    <= '0;
      min_x_q <= '0;
      max_x_q <= '0;
      min_y_q <= '0;
      max_y_q <= '0;
      bx_q    <= '0;
      by_q    <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      cross_q <= '0;
      last_q  <= flw_pkg::NO_MOVE;
      steps_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (exec) begin
        if (cmd_i.is_start) begin
          ex_q    <= cmd_i.ex;
          ey_q    <= cmd_i.ey;
          min_x_q <= cmd_i.min_x;
          max_x_q <= cmd_i.max_x;
          min_y_q <= cmd_i.min_y;
          max_y_q <= cmd_i.max_y;
          bx_q    <= cmd_i.bx;
          by_q    <= cmd_i.by;
          cx_q    <= cmd_i.sx;
          cy_q    <= cmd_i.sy;
          cross_q <= '0;
          last_q  <= flw_pkg::NO_MOVE;
          steps_q <= '0;
        end else if (!at_end && !cap_hit && any_legal) begin
          cx_q    <= nx;
          cy_q    <= ny;
          cross_q <= cross_s[best];
          last_q  <= {1'b0, best};
          steps_q <= steps_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= !oq_wr_q;
      end
      if (oq_pop) begin
        oq_rd_q <= !oq_rd_q;
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + 2'd1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt_q <= oq_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_mem_q[oq_wr_q] <= res;
    end
  end

endmodule

// ----- rtl/core/four_connected_line_walker.sv -----
// four-connected line walker: a pushed item passes the front register,
// the command queue and the step unit into the result queue
// throughput is one item per cycle while the result queue has room; the step unit
// does each step using a running cross product, so no multiplier sits in the loop
// reset: step cap 1000, the end point and the walker at the origin, no last move,
// both queues empty
module four_connected_line_walker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  flw_pkg::in_item_t         in_item_i,
  output logic                      empty,
  input  logic                      pop,
  output flw_pkg::out_item_t        out_item_o,
  input  logic                      cfg_we_i,
  input  logic [flw_pkg::CAP_W-1:0] cfg_wdata_i
);

  logic          f_valid, f_ready;
  flw_pkg::cmd_t f_cmd;
  logic          q_valid, q_ready;
  flw_pkg::cmd_t q_cmd;

  flw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (in_item_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  flw_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_cmd_i    (f_cmd),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_cmd_o   (q_cmd)
  );

  flw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o)
  );

endmodule
